### sv/matrix3x3_inverse_defines.svh
// assertion macros for the 3x3 matrix inverse block
// used by the top level; no other dependencies
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH
`ifndef SYNTHESIS
`define M3I_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define M3I_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define M3I_ASSERT(lbl, clk, rst_n, prop)
`define M3I_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### sv/m3i_pkg.sv
// package for the 3x3 matrix inverse: default widths and cofactor index tables
// no dependencies
`default_nettype none
package m3i_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // cofactor k (row-major order of the inverse) = m[A]*m[B] - m[C]*m[D]
    localparam int COF_A [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int COF_B [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int COF_C [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int COF_D [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    // cofactors that pair with row 0 in the determinant expansion
    localparam int COF_ROW0 [3] = '{0, 3, 6};
endpackage
`default_nettype wire

### sv/m3i_if.sv
// handshake channels of the 3x3 matrix inverse: matrix in, inverse out
// depends on m3i_pkg for default widths
`default_nettype none
interface m3i_mat_if import m3i_pkg::*; #(parameter int DATA_WIDTH = DATA_WIDTH_DEF);
    logic valid;
    logic ready;
    logic signed [DATA_WIDTH-1:0] m_r0c0;
    logic signed [DATA_WIDTH-1:0] m_r0c1;
    logic signed [DATA_WIDTH-1:0] m_r0c2;
    logic signed [DATA_WIDTH-1:0] m_r1c0;
    logic signed [DATA_WIDTH-1:0] m_r1c1;
    logic signed [DATA_WIDTH-1:0] m_r1c2;
    logic signed [DATA_WIDTH-1:0] m_r2c0;
    logic signed [DATA_WIDTH-1:0] m_r2c1;
    logic signed [DATA_WIDTH-1:0] m_r2c2;
    modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                    m_r2c0, m_r2c1, m_r2c2, input ready);
    modport sink (input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                  m_r2c0, m_r2c1, m_r2c2, output ready);
endinterface

interface m3i_inv_if import m3i_pkg::*; #(parameter int DATA_WIDTH = DATA_WIDTH_DEF);
    logic valid;
    logic ready;
    logic signed [DATA_WIDTH-1:0] inv_r0c0;
    logic signed [DATA_WIDTH-1:0] inv_r0c1;
    logic signed [DATA_WIDTH-1:0] inv_r0c2;
    logic signed [DATA_WIDTH-1:0] inv_r1c0;
    logic signed [DATA_WIDTH-1:0] inv_r1c1;
    logic signed [DATA_WIDTH-1:0] inv_r1c2;
    logic signed [DATA_WIDTH-1:0] inv_r2c0;
    logic signed [DATA_WIDTH-1:0] inv_r2c1;
    logic signed [DATA_WIDTH-1:0] inv_r2c2;
    logic singular;
    logic overflow;
    modport source (output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                    inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, singular, overflow,
                    input ready);
    modport sink (input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                  inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, singular, overflow,
                  output ready);
endinterface
`default_nettype wire

### sv/matrix3x3_inverse.sv
// 3x3 matrix inverse by adjugate over determinant, fully pipelined
// depends on m3i_pkg, m3i_if and matrix3x3_inverse_defines.svh
//
// usage: a matrix of nine signed fixed-point elements enters on i_mat, the
// inverse leaves on o_inv with the singular and overflow flags. both channels
// are valid/ready; a transfer happens when both are high.
// pipeline: six arithmetic stages (operand register, cofactor products,
// cofactors, determinant partial products, determinant, determinant magnitude),
// DATA_WIDTH + 1 restoring division steps (one quotient bit per stage, nine
// lanes), and the saturating output register. throughput is one matrix per
// cycle while o_inv is not stalled.
// the whole pipeline advances together: when o_inv holds a result that is not
// taken, every stage holds and i_mat.ready drops; nothing is lost or repeated.
// i_mat.ready stays high while the output register is empty or being drained.
// reset clears the valid bits only; no results are pending after reset.
`default_nettype none
`include "matrix3x3_inverse_defines.svh"
module matrix3x3_inverse import m3i_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    m3i_mat_if.sink     i_mat,
    m3i_inv_if.source   o_inv
);
    localparam int W   = DATA_WIDTH;
    localparam int PW  = 2 * W;          // one element product
    localparam int CFW = 2 * W + 1;      // cofactor, signed
    localparam int DW  = 3 * W + 3;      // determinant, signed
    localparam int NW  = CFW + 2 * FRAC_BITS;
    localparam int CW  = ((NW > DW + W) ? NW : DW + W) + 1;
    localparam int NS  = W + 1;          // quotient bits including the overflow bit
    localparam int NV  = NS + 7;

    logic en;
    logic [NV-1:0] r_vld;

    logic signed [W-1:0]   m_in [9];
    logic signed [W-1:0]   r_m [9];
    logic signed [PW-1:0]  r_pa [9];
    logic signed [PW-1:0]  r_pb [9];
    logic signed [W-1:0]   r_m2 [3];
    logic signed [W-1:0]   r_m3 [3];
    logic signed [CFW-1:0] r_cof [9];
    logic signed [CFW-1:0] r_cof4 [9];
    logic signed [CFW-1:0] r_plo [3];
    logic signed [CFW-1:0] r_phi [3];
    logic signed [DW-1:0]  n_det;
    logic signed [DW-1:0]  r_det;
    logic [CFW-1:0]        r_cmag5 [9];
    logic [8:0]            r_cneg5;
    logic [CFW-1:0]        r_cmag6 [9];
    logic [8:0]            r_cneg6;
    logic [DW-1:0]         r_dmag6;
    logic                  r_dneg6;
    logic                  r_sing6;

    logic [CW-1:0] r_rem [NS][9];
    logic [CW-1:0] n_rem [NS][9];
    logic [W:0]    r_q   [NS][9];
    logic [W:0]    n_q   [NS][9];
    logic [8:0]    r_cn  [NS];
    logic [DW-1:0] r_dm  [NS];
    logic [NS-1:0] r_dn;
    logic [NS-1:0] r_sg;

    logic signed [W-1:0] r_inv [9];
    logic signed [W-1:0] n_inv [9];
    logic r_sing_o, r_ovf_o, n_ovf;
    logic diag_zero;

    assign en          = !r_vld[NV-1] || o_inv.ready;
    assign i_mat.ready = en;

    assign m_in[0] = i_mat.m_r0c0;
    assign m_in[1] = i_mat.m_r0c1;
    assign m_in[2] = i_mat.m_r0c2;
    assign m_in[3] = i_mat.m_r1c0;
    assign m_in[4] = i_mat.m_r1c1;
    assign m_in[5] = i_mat.m_r1c2;
    assign m_in[6] = i_mat.m_r2c0;
    assign m_in[7] = i_mat.m_r2c1;
    assign m_in[8] = i_mat.m_r2c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_mat.valid};
        end
    end

    // front arithmetic stages
    always_comb begin
        n_det = '0;
        for (int j = 0; j < 3; j++) begin
            n_det = n_det + (DW'(r_phi[j]) <<< W) + DW'(r_plo[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                r_m[k]  <= m_in[k];
                r_pa[k] <= PW'(r_m[COF_A[k]]) * PW'(r_m[COF_B[k]]);
                r_pb[k] <= PW'(r_m[COF_C[k]]) * PW'(r_m[COF_D[k]]);
                r_cof[k]  <= CFW'(r_pa[k]) - CFW'(r_pb[k]);
                r_cof4[k] <= r_cof[k];
                r_cneg5[k] <= r_cof4[k][CFW-1];
                r_cmag5[k] <= r_cof4[k][CFW-1] ? CFW'(-r_cof4[k]) : CFW'(r_cof4[k]);
                r_cmag6[k] <= r_cmag5[k];
                r_cneg6[k] <= r_cneg5[k];
            end
            for (int j = 0; j < 3; j++) begin
                r_m2[j] <= r_m[j];
                r_m3[j] <= r_m2[j];
                // split the cofactor so each multiply stays near word size
                r_plo[j] <= CFW'(r_m3[j]) *
                            CFW'($signed({1'b0, r_cof[COF_ROW0[j]][W-1:0]}));
                r_phi[j] <= CFW'(r_m3[j]) * CFW'($signed(r_cof[COF_ROW0[j]][CFW-1:W]));
            end
            r_det   <= n_det;
            r_dneg6 <= r_det[DW-1];
            r_dmag6 <= r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
            r_sing6 <= (r_det == '0);
        end
    end

    // restoring division, one quotient bit per stage, msb (overflow bit) first
    always_comb begin
        logic [CW-1:0] src_rem;
        logic [W:0]    src_q;
        logic [DW-1:0] src_d;
        logic [CW-1:0] sh;
        for (int j = 0; j < NS; j++) begin
            for (int k = 0; k < 9; k++) begin
                if (j == 0) begin
                    src_rem = CW'({r_cmag6[k], {(2 * FRAC_BITS){1'b0}}});
                    src_q   = '0;
                    src_d   = r_dmag6;
                end else begin
                    src_rem = r_rem[j-1][k];
                    src_q   = r_q[j-1][k];
                    src_d   = r_dm[j-1];
                end
                sh = CW'(src_d) << (W - j);
                n_q[j][k] = src_q;
                if (src_rem >= sh) begin
                    n_rem[j][k]       = src_rem - sh;
                    n_q[j][k][W - j]  = 1'b1;
                end else begin
                    n_rem[j][k] = src_rem;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < NS; j++) begin
                for (int k = 0; k < 9; k++) begin
                    r_rem[j][k] <= n_rem[j][k];
                    r_q[j][k]   <= n_q[j][k];
                end
                if (j == 0) begin
                    r_cn[j] <= r_cneg6;
                    r_dm[j] <= r_dmag6;
                    r_dn[j] <= r_dneg6;
                    r_sg[j] <= r_sing6;
                end else begin
                    r_cn[j] <= r_cn[j-1];
                    r_dm[j] <= r_dm[j-1];
                    r_dn[j] <= r_dn[j-1];
                    r_sg[j] <= r_sg[j-1];
                end
            end
        end
    end

    // sign and saturation
    always_comb begin
        logic [W:0] q;
        n_ovf = 1'b0;
        for (int k = 0; k < 9; k++) begin
            q = r_q[NS-1][k];
            if (r_sg[NS-1]) begin
                n_inv[k] = '0;
            end else if (r_cn[NS-1][k] != r_dn[NS-1]) begin
                if (q[W] || (q[W-1] && (q[W-2:0] != '0))) begin
                    n_inv[k] = {1'b1, {(W-1){1'b0}}};
                    n_ovf    = 1'b1;
                end else begin
                    n_inv[k] = $signed(-q[W-1:0]);
                end
            end else begin
                if (q[W] || q[W-1]) begin
                    n_inv[k] = {1'b0, {(W-1){1'b1}}};
                    n_ovf    = 1'b1;
                end else begin
                    n_inv[k] = $signed(q[W-1:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_inv    <= n_inv;
            r_sing_o <= r_sg[NS-1];
            r_ovf_o  <= n_ovf;
        end
    end

    assign o_inv.valid    = r_vld[NV-1];
    assign o_inv.inv_r0c0 = r_inv[0];
    assign o_inv.inv_r0c1 = r_inv[1];
    assign o_inv.inv_r0c2 = r_inv[2];
    assign o_inv.inv_r1c0 = r_inv[3];
    assign o_inv.inv_r1c1 = r_inv[4];
    assign o_inv.inv_r1c2 = r_inv[5];
    assign o_inv.inv_r2c0 = r_inv[6];
    assign o_inv.inv_r2c1 = r_inv[7];
    assign o_inv.inv_r2c2 = r_inv[8];
    assign o_inv.singular = r_sing_o;
    assign o_inv.overflow = r_ovf_o;

    assign diag_zero = (r_inv[0] == '0) && (r_inv[4] == '0) && (r_inv[8] == '0);

    // a stalled pipeline keeps every valid bit in place
    `M3I_ASSERT(a_stall_holds, i_clk, i_rst_n, !en |=> $stable(r_vld))
    `M3I_ASSERT(a_sing_no_ovf, i_clk, i_rst_n, (o_inv.valid && o_inv.singular) |-> !o_inv.overflow)
    `M3I_ASSERT(a_sing_zero, i_clk, i_rst_n, (o_inv.valid && o_inv.singular) |-> diag_zero)
    `M3I_ASSERT(a_ready_follows, i_clk, i_rst_n, (!r_vld[NV-1]) |-> i_mat.ready)
endmodule
`default_nettype wire

### test/matrix3x3_inverse_tb.sv
// testbench for the 3x3 matrix inverse: random and directed matrices, scoreboard checks
// depends on m3i_pkg, m3i_if and the matrix3x3_inverse top level
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
    logic signed [31:0] el [9];
    logic               singular;
    logic               overflow;
} inv_result_t;

class inverse_scoreboard;
    inv_result_t pending [$];
    int          mismatches;
    int          checked;
    int          singular_seen;
    int          overflow_seen;

    // exact adjugate over determinant, quotient truncated toward zero then saturated
    function inv_result_t compute_inverse(logic signed [31:0] m [9]);
        inv_result_t          r;
        logic signed [127:0]  w [9];
        logic signed [127:0]  cof [9];
        logic signed [127:0]  det;
        logic        [127:0]  dmag;
        logic        [127:0]  cmag;
        logic        [191:0]  num;
        logic        [191:0]  q;
        logic                 neg;
        logic                 ovf;
        for (int i = 0; i < 9; i++) w[i] = m[i];
        cof[0] = w[4] * w[8] - w[5] * w[7];
        cof[1] = w[2] * w[7] - w[1] * w[8];
        cof[2] = w[1] * w[5] - w[2] * w[4];
        cof[3] = w[5] * w[6] - w[3] * w[8];
        cof[4] = w[0] * w[8] - w[2] * w[6];
        cof[5] = w[2] * w[3] - w[0] * w[5];
        cof[6] = w[3] * w[7] - w[4] * w[6];
        cof[7] = w[1] * w[6] - w[0] * w[7];
        cof[8] = w[0] * w[4] - w[1] * w[3];
        det = w[0] * cof[0] + w[1] * cof[3] + w[2] * cof[6];
        ovf = 1'b0;
        if (det == 0) begin
            for (int k = 0; k < 9; k++) r.el[k] = '0;
            r.singular = 1'b1;
            r.overflow = 1'b0;
            return r;
        end
        dmag = det[127] ? -det : det;
        for (int k = 0; k < 9; k++) begin
            cmag = cof[k][127] ? -cof[k] : cof[k];
            num  = {64'd0, cmag} << 32;
            q    = num / {64'd0, dmag};
            neg  = cof[k][127] != det[127];
            if (neg) begin
                if (q > 192'h8000_0000) begin
                    r.el[k] = 32'h8000_0000;
                    ovf = 1'b1;
                end else begin
                    r.el[k] = -q[31:0];
                end
            end else begin
                if (q > 192'h7fff_ffff) begin
                    r.el[k] = 32'h7fff_ffff;
                    ovf = 1'b1;
                end else begin
                    r.el[k] = q[31:0];
                end
            end
        end
        r.singular = 1'b0;
        r.overflow = ovf;
        return r;
    endfunction

    function void note_matrix(logic signed [31:0] m [9]);
        pending.push_back(compute_inverse(m));
    endfunction

    function void check_inverse(inv_result_t got);
        inv_result_t exp_r;
        bit          bad;
        checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result with nothing pending");
            return;
        end
        exp_r = pending.pop_front();
        bad = (got.singular !== exp_r.singular) || (got.overflow !== exp_r.overflow);
        for (int k = 0; k < 9; k++) if (got.el[k] !== exp_r.el[k]) bad = 1;
        if (got.singular === 1'b1) singular_seen++;
        if (got.overflow === 1'b1) overflow_seen++;
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on result %0d: sing %b/%b ovf %b/%b",
                         checked, exp_r.singular, got.singular,
                         exp_r.overflow, got.overflow);
                for (int k = 0; k < 9; k++)
                    $display("  el %0d expected %h actual %h", k, exp_r.el[k], got.el[k]);
            end
        end
    endfunction
endclass

module matrix3x3_inverse_tb;
    import m3i_pkg::*;

    localparam int RANDOM_ITEMS = 530;
    localparam int WATCHDOG     = 20000;
    localparam int LATENCY      = DATA_WIDTH_DEF + 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    m3i_mat_if mat_ch ();
    m3i_inv_if inv_ch ();

    matrix3x3_inverse dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat_ch.sink),
        .o_inv   (inv_ch.source)
    );

    always #5 i_clk = ~i_clk;

    inverse_scoreboard sb = new();
    int sent;
    int idle_cycles;
    bit stall_mode;

    initial begin
        mat_ch.valid  = 1'b0;
        mat_ch.m_r0c0 = '0; mat_ch.m_r0c1 = '0; mat_ch.m_r0c2 = '0;
        mat_ch.m_r1c0 = '0; mat_ch.m_r1c1 = '0; mat_ch.m_r1c2 = '0;
        mat_ch.m_r2c0 = '0; mat_ch.m_r2c1 = '0; mat_ch.m_r2c2 = '0;
        inv_ch.ready  = 1'b0;
    end

    // receiver: stretches of no stall alternate with random stall patterns
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            inv_ch.ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) == 0) stall_mode = ~stall_mode;
            inv_ch.ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        inv_result_t got;
        if (i_rst_n && inv_ch.valid && inv_ch.ready) begin
            got.el[0] = inv_ch.inv_r0c0; got.el[1] = inv_ch.inv_r0c1;
            got.el[2] = inv_ch.inv_r0c2; got.el[3] = inv_ch.inv_r1c0;
            got.el[4] = inv_ch.inv_r1c1; got.el[5] = inv_ch.inv_r1c2;
            got.el[6] = inv_ch.inv_r2c0; got.el[7] = inv_ch.inv_r2c1;
            got.el[8] = inv_ch.inv_r2c2;
            got.singular = inv_ch.singular;
            got.overflow = inv_ch.overflow;
            sb.check_inverse(got);
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((mat_ch.valid && mat_ch.ready) || (inv_ch.valid && inv_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // drive one matrix and hold it until the transfer
    task automatic send_matrix(logic signed [31:0] m [9]);
        mat_ch.valid  <= 1'b1;
        mat_ch.m_r0c0 <= m[0]; mat_ch.m_r0c1 <= m[1]; mat_ch.m_r0c2 <= m[2];
        mat_ch.m_r1c0 <= m[3]; mat_ch.m_r1c1 <= m[4]; mat_ch.m_r1c2 <= m[5];
        mat_ch.m_r2c0 <= m[6]; mat_ch.m_r2c1 <= m[7]; mat_ch.m_r2c2 <= m[8];
        @(posedge i_clk);
        while (!mat_ch.ready) @(posedge i_clk);
        sb.note_matrix(m);
        sent++;
    endtask

    task automatic idle_sender(int n);
        mat_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
            2: return 32'(signed'($urandom_range(0, 255)) - 128);
            3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17));
        endcase
    endfunction

    task automatic send_scaled_identity(logic signed [31:0] a, b, c);
        logic signed [31:0] m [9];
        m = '{a, 0, 0, 0, b, 0, 0, 0, c};
        send_matrix(m);
    endtask

    initial begin
        logic signed [31:0] m [9];
        int burst;
        sent = 0;
        idle_cycles = 0;
        stall_mode = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity, negative determinant, tiny and huge diagonals
        send_scaled_identity(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_scaled_identity(32'hffff_0000, 32'h0001_0000, 32'h0001_0000);
        send_scaled_identity(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        send_scaled_identity(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_scaled_identity(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_scaled_identity(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        send_scaled_identity(32'h0002_0000, 32'h0000_8000, 32'hfffc_0000);
        // zero matrix and rank-deficient ones
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(m);
        m = '{32'h10000, 32'h20000, 32'h30000, 32'h20000, 32'h40000, 32'h60000,
              32'h1, 32'h2, 32'h3};
        send_matrix(m);
        m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; send_matrix(m);
        // all-extreme elements, then extremes mixed with zeros
        for (int i = 0; i < 9; i++) m[i] = (i % 2) ? 32'h7fff_ffff : 32'h8000_0000;
        send_matrix(m);
        m = '{32'h7fff_ffff, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
              32'h8000_0000, 0, 32'h7fff_ffff};
        send_matrix(m);
        // a general well-conditioned matrix and its negation
        m = '{32'h20000, 32'h10000, 0, 32'h10000, 32'h30000, 32'h10000,
              0, 32'h10000, 32'h40000};
        send_matrix(m);
        for (int i = 0; i < 9; i++) m[i] = -m[i];
        send_matrix(m);

        // hold off until the pipe is empty
        mat_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);

        while (sent < 14 + RANDOM_ITEMS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                for (int i = 0; i < 9; i++) m[i] = rand_elem();
                // occasionally force a singular matrix by copying a row
                if ($urandom_range(0, 9) == 0) begin
                    m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
                end
                send_matrix(m);
            end
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
        end
        mat_ch.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("sent %0d matrices, checked %0d inverses (%0d singular, %0d saturated)",
                 sent, sb.checked, sb.singular_seen, sb.overflow_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
